[design/gpuf_pkg.sv]
package gpuf_pkg;

  localparam int unsigned GridMax   = 32;
  localparam int unsigned GridReset = 32;
  localparam int unsigned Nodes     = GridMax * GridMax + 2;
  localparam int unsigned NodeW     = $clog2(Nodes);
  localparam int unsigned SiteW     = $clog2(GridMax * GridMax);
  localparam int unsigned CoordW    = 5;
  localparam int unsigned SizeW     = 6;
  localparam int unsigned CountW    = 11;

  typedef logic [NodeW-1:0] node_t;

  localparam logic OpQuery = 1'b0;
  localparam logic OpOpen  = 1'b1;

  typedef struct packed {
    logic              site_open;
    logic              site_full;
    logic              percolates;
    logic [CountW-1:0] open_count;
    logic              error;
  } result_t;

endpackage

[design/grid_percolation_union_find_top.sv]
// Each find walks up the tree one level at a time (at most ten levels); an open runs up to four
//   unions of two finds each, and the report runs four finds, or two for an out-of-range beat.
// Throughput: one beat in work at a time; the next beat is taken while the last result waits.
// Reset or a grid_size write runs a clearing sweep over all Nodes (1026) entries, then 2*grid_size
//   edge joins; no beat is accepted meanwhile.
module grid_percolation_union_find_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,      // grid_size[5:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // operation[0], row[5:1], column[10:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // site_open, site_full, percolates, open_count, error
);

  localparam int unsigned NW = gpuf_pkg::NodeW;
  localparam int unsigned SW = gpuf_pkg::SiteW;

  localparam logic [4:0] StClr = 5'd0, StInit = 5'd1, StIdle = 5'd2, StNbr = 5'd3,
    StNbrW = 5'd4, StFindA = 5'd5, StFindAW = 5'd6, StFindB = 5'd7, StFindBW = 5'd8,
    StSzA = 5'd9, StSzAW = 5'd10, StSzBW = 5'd11, StLink = 5'd12, StRep1 = 5'd13,
    StRep2 = 5'd14, StOut = 5'd15, StOpenW = 5'd16;

  logic [4:0] st_q;

  logic [NW-1:0] par_mem [gpuf_pkg::Nodes];
  logic [NW-1:0] sz_mem  [gpuf_pkg::Nodes];
  logic          open_mem [gpuf_pkg::GridMax * gpuf_pkg::GridMax];

  logic          par_we, sz_we, open_we;
  logic [NW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
  logic [NW-1:0] sz_waddr, sz_wdata, sz_raddr, sz_rdata;
  logic [SW-1:0] open_waddr, open_raddr;
  logic          open_wdata, open_rdata;

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_waddr] <= par_wdata;
    par_rdata <= par_mem[par_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (sz_we) sz_mem[sz_waddr] <= sz_wdata;
    sz_rdata <= sz_mem[sz_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (open_we) open_mem[open_waddr] <= open_wdata;
    open_rdata <= open_mem[open_raddr];
  end

  logic [gpuf_pkg::SizeW-1:0]  g_q;
  logic [NW-1:0]               top_q, cnt_q;
  logic [gpuf_pkg::CountW-1:0] total_q;
  logic                        op_q, err_q, sopen_q, sfull_q, perc_q;
  logic [gpuf_pkg::CoordW-1:0] r_q, c_q;
  logic [NW-1:0]               s_q, q_q, x_q, a_q, b_q, sza_q;
  logic [2:0]                  nb_q;  // 0..3 neighbours, 4 reporting
  logic [1:0]                  rep_q; // 0 site vs top, 1 top vs bottom
  logic                        init_q, side_q;
  gpuf_pkg::result_t           res_q;
  logic                        ovalid_q;

  logic [5:0] gv;
  always_comb begin
    gv = cfg_data_i[5:0];
    if (gv == 6'd0) gv = 6'd1;
    else if (gv > 6'(gpuf_pkg::GridMax)) gv = 6'(gpuf_pkg::GridMax);
  end

  assign cfg_ready_o   = (st_q == StIdle) && !ovalid_q;
  assign s_axis_tready = (st_q == StIdle) && !cfg_valid_i;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, res_q.error, res_q.open_count, res_q.percolates,
                          res_q.site_full, res_q.site_open};

  logic [NW-1:0] g_ext;
  assign g_ext = NW'(g_q);

  // neighbour selection
  logic          nb_ok;
  logic [NW-1:0] nb_node;
  always_comb begin
    nb_ok = 1'b0;
    nb_node = s_q;
    unique case (nb_q)
      3'd0: begin nb_ok = r_q != 0; nb_node = s_q - g_ext; end
      3'd1: begin nb_ok = (NW'(c_q) + 1) < g_ext; nb_node = s_q + 1'b1; end
      3'd2: begin nb_ok = (NW'(r_q) + 1) < g_ext; nb_node = s_q + g_ext; end
      3'd3: begin nb_ok = c_q != 0; nb_node = s_q - 1'b1; end
      default: ;
    endcase
  end

  logic [NW-1:0] s_new;
  assign s_new = NW'(s_axis_tdata[5:1]) * g_ext + NW'(s_axis_tdata[10:6]);

  always_comb begin
    par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_raddr = x_q;
    sz_we = 1'b0; sz_waddr = '0; sz_wdata = '0; sz_raddr = a_q;
    open_we = 1'b0; open_waddr = '0; open_wdata = 1'b0; open_raddr = nb_node[SW-1:0];
    unique case (st_q)
      StClr: begin
        par_we = 1'b1; par_waddr = cnt_q; par_wdata = cnt_q;
        sz_we = 1'b1; sz_waddr = cnt_q; sz_wdata = NW'(1);
        if (cnt_q < NW'(gpuf_pkg::GridMax * gpuf_pkg::GridMax)) begin
          open_we = 1'b1; open_waddr = cnt_q[SW-1:0];
        end
      end
      StIdle: open_raddr = s_new[SW-1:0];
      StSzA: sz_raddr = a_q;
      StSzAW: sz_raddr = b_q;
      StSzBW: sz_raddr = b_q;
      StLink: begin
        par_we = 1'b1;
        sz_we  = 1'b1;
        if (sza_q < sz_rdata) begin
          par_waddr = a_q; par_wdata = b_q; sz_waddr = b_q; sz_wdata = sz_rdata + sza_q;
        end else begin
          par_waddr = b_q; par_wdata = a_q; sz_waddr = a_q; sz_wdata = sz_rdata + sza_q;
        end
      end
      StOpenW: begin
        open_we = (op_q == gpuf_pkg::OpOpen) && !err_q;
        open_waddr = s_q[SW-1:0]; open_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  // control FSM: clearing sweep, edge joins, beat intake, finds, unions and reports
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; cnt_q <= '0; g_q <= 6'(gpuf_pkg::GridReset);
      top_q <= NW'(gpuf_pkg::GridReset * gpuf_pkg::GridReset);
      total_q <= '0; ovalid_q <= 1'b0; init_q <= 1'b1;
    end else begin
      if (ovalid_q && m_axis_tready && st_q != StOut) ovalid_q <= 1'b0;
      unique case (st_q)
        StClr: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == NW'(gpuf_pkg::Nodes - 1)) begin
            st_q <= StInit; cnt_q <= '0; side_q <= 1'b0;
          end
        end
        StInit: begin
          if (cnt_q == g_ext) begin
            st_q <= StIdle; init_q <= 1'b0;
          end else begin
            q_q <= side_q ? top_q + 1'b1 : top_q;
            x_q <= side_q ? (g_ext - 1'b1) * g_ext + cnt_q : cnt_q;
            side_q <= !side_q;
            if (side_q) cnt_q <= cnt_q + 1'b1;
            st_q <= StFindA;
          end
        end
        StIdle: begin
          if (cfg_valid_i && cfg_ready_o) begin
            g_q <= gv; top_q <= NW'(gv) * NW'(gv); total_q <= '0;
            cnt_q <= '0; init_q <= 1'b1; st_q <= StClr;
          end else if (s_axis_tvalid && s_axis_tready) begin
            op_q <= s_axis_tdata[0];
            r_q  <= s_axis_tdata[5:1];
            c_q  <= s_axis_tdata[10:6];
            s_q  <= s_new;
            err_q <= (6'(s_axis_tdata[5:1]) >= g_q) || (6'(s_axis_tdata[10:6]) >= g_q);
            st_q <= StOpenW;
          end
        end
        StOpenW: begin
          // open_rdata holds the site's old open bit here
          if (err_q) begin
            sopen_q <= 1'b0; rep_q <= 2'd1; nb_q <= 3'd4;
            x_q <= top_q; st_q <= StFindA;
          end else if (op_q == gpuf_pkg::OpOpen) begin
            if (!open_rdata) total_q <= total_q + 1'b1;
            sopen_q <= 1'b1; nb_q <= 3'd0; st_q <= StNbr;
          end else begin
            sopen_q <= open_rdata; rep_q <= 2'd0; nb_q <= 3'd4;
            x_q <= s_q; st_q <= StFindA;
          end
        end
        StNbr: begin
          if (nb_q == 3'd4) begin
            rep_q <= 2'd0; x_q <= s_q; st_q <= StFindA;
          end else st_q <= StNbrW;
        end
        StNbrW: begin
          if (nb_ok && open_rdata) begin
            q_q <= nb_node; x_q <= s_q; st_q <= StFindA;
          end else begin
            nb_q <= nb_q + 1'b1; st_q <= StNbr;
          end
        end
        StFindA: st_q <= StFindAW;
        StFindAW: begin
          if (par_rdata == x_q) begin
            a_q <= x_q;
            x_q <= (init_q || nb_q != 3'd4) ? q_q : (rep_q == 2'd0 ? top_q : top_q + 1'b1);
            st_q <= StFindB;
          end else begin
            x_q <= par_rdata; st_q <= StFindA;
          end
        end
        StFindB: st_q <= StFindBW;
        StFindBW: begin
          if (par_rdata == x_q) begin
            b_q <= x_q;
            if (!init_q && nb_q == 3'd4) st_q <= StRep1;
            else if (a_q == x_q) st_q <= init_q ? StInit : StRep2;
            else st_q <= StSzA;
          end else begin
            x_q <= par_rdata; st_q <= StFindB;
          end
        end
        StSzA: st_q <= StSzAW;
        StSzAW: begin sza_q <= sz_rdata; st_q <= StSzBW; end
        StSzBW: st_q <= StLink;
        StLink: st_q <= init_q ? StInit : StRep2;
        StRep2: begin nb_q <= nb_q + 1'b1; st_q <= StNbr; end
        StRep1: begin
          if (rep_q == 2'd0) begin
            sfull_q <= sopen_q && (a_q == b_q);
            rep_q <= 2'd1; x_q <= top_q; st_q <= StFindA;
          end else begin
            if (err_q) sfull_q <= 1'b0;
            perc_q <= a_q == b_q;
            st_q <= StOut;
          end
        end
        StOut: begin
          if (!ovalid_q || m_axis_tready) begin
            res_q.site_open  <= sopen_q;
            res_q.site_full  <= err_q ? 1'b0 : sfull_q;
            res_q.percolates <= perc_q;
            res_q.open_count <= total_q;
            res_q.error      <= err_q;
            ovalid_q <= 1'b1;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  logic unused;
  assign unused = ^{s_axis_tdata[15:11], cfg_data_i[7:6]};

endmodule

[dv/grid_percolation_union_find_top_tb.sv]
`timescale 1ns / 1ps

module grid_percolation_union_find_top_tb;

  localparam int unsigned NumNodes  = gpuf_pkg::GridMax * gpuf_pkg::GridMax + 2;
  localparam int unsigned Latency   = 150;
  localparam int unsigned CycleCap  = 5000000;
  localparam int unsigned HoldSpan  = 400;

  typedef enum logic [1:0] {BeatSite, BeatSize, BeatDrain} beat_kind_e;

  typedef struct packed {
    beat_kind_e  kind;
    logic        op;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [7:0]  size;
  } beat_t;

  typedef struct packed {
    logic                        site_open;
    logic                        site_full;
    logic                        percolates;
    logic [gpuf_pkg::CountW-1:0] open_count;
    logic                        error;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  grid_percolation_union_find_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  beat_t    pending_beats[$];
  verdict_t expected_verdicts[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sites_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned resizes = 0;
  int unsigned settle;
  bit          held_once;
  int unsigned hold_left;

  // percolation shadow state
  int unsigned side;
  bit          site_is_open[gpuf_pkg::GridMax*gpuf_pkg::GridMax];
  int unsigned parent[NumNodes];
  int unsigned weight[NumNodes];
  int unsigned opened;

  function automatic int unsigned root_of(int unsigned x);
    while (parent[x] != x) x = parent[x];
    return x;
  endfunction

  function automatic void merge(int unsigned p, int unsigned q);
    int unsigned a;
    int unsigned b;
    a = root_of(p);
    b = root_of(q);
    if (a == b) return;
    if (weight[a] < weight[b]) begin
      parent[a] = b;
      weight[b] += weight[a];
    end else begin
      parent[b] = a;
      weight[a] += weight[b];
    end
  endfunction

  function automatic void resize_grid(logic [5:0] v);
    int unsigned topn;
    side = (v < 1) ? 1 : (v > gpuf_pkg::GridMax) ? gpuf_pkg::GridMax : v;
    topn = side * side;
    foreach (site_is_open[i]) site_is_open[i] = 1'b0;
    for (int unsigned i = 0; i < NumNodes; i++) begin
      parent[i] = i;
      weight[i] = 1;
    end
    opened = 0;
    for (int unsigned i = 0; i < side; i++) begin
      merge(i, topn);
      merge((side - 1) * side + i, topn + 1);
    end
  endfunction

  function automatic verdict_t percolate_step(logic op, logic [4:0] r, logic [4:0] c);
    verdict_t v;
    int unsigned s;
    int unsigned topn;
    topn = side * side;
    v = '0;
    if (r >= side || c >= side) begin
      v.error = 1'b1;
    end else begin
      s = r * side + c;
      if (op == gpuf_pkg::OpOpen) begin
        if (!site_is_open[s]) begin
          site_is_open[s] = 1'b1;
          opened++;
        end
        if (r > 0 && site_is_open[s-side]) merge(s, s - side);
        if (c + 1 < side && site_is_open[s+1]) merge(s, s + 1);
        if (r + 1 < side && site_is_open[s+side]) merge(s, s + side);
        if (c > 0 && site_is_open[s-1]) merge(s, s - 1);
      end
      v.site_open = site_is_open[s];
      v.site_full = site_is_open[s] && root_of(s) == root_of(topn);
    end
    v.percolates = root_of(topn) == root_of(topn + 1);
    v.open_count = opened[gpuf_pkg::CountW-1:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %0s at verdict %0d: got %0d want %0d", what, verdicts_seen, got, want);
    errors++;
  endtask

  function automatic void queue_beat(beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic beat_t site_beat(logic op, int unsigned r, int unsigned c);
    beat_t b;
    b = '0;
    b.kind = BeatSite;
    b.op = op;
    b.row = r[4:0];
    b.col = c[4:0];
    return b;
  endfunction

  function automatic beat_t size_beat(int unsigned v);
    beat_t b;
    b = '0;
    b.kind = BeatSize;
    b.size = v[7:0];
    return b;
  endfunction

  function automatic beat_t drain_beat();
    beat_t b;
    b = '0;
    b.kind = BeatDrain;
    return b;
  endfunction

  function automatic bit calm();
    return cycles > 20000 && cycles < 30000;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : sender
    logic  site_busy;
    logic  size_busy;
    logic  next_site_valid;
    logic  next_size_valid;
    beat_t head;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      cfg_valid_i   <= 1'b0;
      cfg_data_i    <= '0;
      settle        <= 0;
    end else begin
      site_busy = s_axis_tvalid;
      size_busy = cfg_valid_i;
      settle <= (expected_verdicts.size() == 0) ? settle + 1 : 0;
      if (s_axis_tvalid && s_axis_tready) begin
        head = pending_beats.pop_front();
        expected_verdicts.insert(expected_verdicts.size(),
                                 percolate_step(head.op, head.row, head.col));
        sites_sent++;
        site_busy = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        head = pending_beats.pop_front();
        resize_grid(head.size[5:0]);
        resizes++;
        size_busy = 1'b0;
      end
      next_site_valid = site_busy;
      next_size_valid = size_busy;
      if (!site_busy && !size_busy && pending_beats.size() > 0) begin
        head = pending_beats[0];
        case (head.kind)
          BeatSite: begin
            if (calm() || $urandom_range(99) >= 21) begin
              next_site_valid = 1'b1;
              s_axis_tdata <= {5'b0, head.col, head.row, head.op};
            end
          end
          BeatSize: begin
            if (expected_verdicts.size() == 0 && settle >= Latency) begin
              next_size_valid = 1'b1;
              cfg_data_i <= head.size;
            end
          end
          default: begin
            if (expected_verdicts.size() == 0) void'(pending_beats.pop_front());
          end
        endcase
      end
      s_axis_tvalid <= next_site_valid;
      cfg_valid_i   <= next_size_valid;
    end
  end

  // receiver readiness, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      held_once     <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!held_once && sites_sent >= 400) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldSpan;
      held_once     <= 1'b1;
    end else begin
      m_axis_tready <= calm() || $urandom_range(99) >= 21;
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.site_open)
          report_mismatch("site_open", m_axis_tdata[0], want.site_open);
        if (m_axis_tdata[1] !== want.site_full)
          report_mismatch("site_full", m_axis_tdata[1], want.site_full);
        if (m_axis_tdata[2] !== want.percolates)
          report_mismatch("percolates", m_axis_tdata[2], want.percolates);
        if (m_axis_tdata[13:3] !== want.open_count)
          report_mismatch("open_count", m_axis_tdata[13:3], want.open_count);
        if (m_axis_tdata[14] !== want.error)
          report_mismatch("error", m_axis_tdata[14], want.error);
      end
      verdicts_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("[grid_percolation_union_find_top] ERROR");
      $finish;
    end
  end

  task automatic random_phase(int unsigned g, int unsigned n);
    int unsigned lim;
    int unsigned roll;
    queue_beat(size_beat(($urandom_range(3) << 6) | g));
    lim = (g > 32) ? 32 : (g < 1 ? 1 : g);
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 8)
        queue_beat(site_beat($urandom_range(1), $urandom_range(31), $urandom_range(31)));
      else if (roll < 25)
        queue_beat(site_beat(gpuf_pkg::OpQuery, $urandom_range(lim - 1),
                             $urandom_range(lim - 1)));
      else
        queue_beat(site_beat(gpuf_pkg::OpOpen, $urandom_range(lim - 1),
                             $urandom_range(lim - 1)));
    end
  endtask

  initial begin
    resize_grid(gpuf_pkg::GridReset);
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full-size corners, then one-site grid, then clamped sizes, then a two-by-two grid
    queue_beat(site_beat(gpuf_pkg::OpQuery, 0, 0));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 0, 0));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 0, 0));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 31, 31));
    queue_beat(site_beat(gpuf_pkg::OpQuery, 31, 0));
    queue_beat(size_beat(1));
    queue_beat(site_beat(gpuf_pkg::OpQuery, 0, 0));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 0, 0));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 1, 0));
    queue_beat(site_beat(gpuf_pkg::OpQuery, 31, 31));
    queue_beat(size_beat(0));
    queue_beat(site_beat(gpuf_pkg::OpQuery, 0, 0));
    queue_beat(size_beat(8'hFF));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 31, 0));
    queue_beat(size_beat(2));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 0, 1));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 1, 1));
    queue_beat(site_beat(gpuf_pkg::OpQuery, 0, 1));
    queue_beat(site_beat(gpuf_pkg::OpOpen, 0, 2));
    queue_beat(site_beat(gpuf_pkg::OpQuery, 2, 0));
    queue_beat(drain_beat());

    random_phase(32, 350);
    queue_beat(drain_beat());
    for (int unsigned p = 0; p < 30; p++) random_phase($urandom_range(2, 8), 25);
    random_phase(31, 100);
    random_phase(1, 20);
    random_phase(33, 20);

    while (pending_beats.size() != 0 || expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    $display("covered %0d site beats, %0d grid resizes, %0d results checked",
             sites_sent, resizes, verdicts_seen);
    if (errors == 0) begin
      $display("[grid_percolation_union_find_top] OK");
    end else begin
      $display("[grid_percolation_union_find_top] ERROR");
    end
    $finish;
  end

endmodule
